### hdl/lruvs_pkg.sv
// ----------------------------------------------------------------------------
// LRU victim select package
// Field widths, operation codes, register indexes and the controller/datapath
// interface types shared by the LRU victim select block.
// ----------------------------------------------------------------------------
package lruvs_pkg;

  // Fixed field widths
  localparam int OP_W        = 2;
  localparam int WAY_FIELD_W = 3;
  localparam int MASK_W      = 8;
  localparam int AGE_FIELD_W = 3;
  localparam int ATT_FIELD_W = 2;
  localparam int LIMIT_W     = 3;
  localparam int RSV_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_HIT        = 2'd0;
  localparam logic [OP_W-1:0] OP_VICTIM     = 2'd1;
  localparam logic [OP_W-1:0] OP_RSV_VICTIM = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_WAYS = 1'd1;

  // Controller -> datapath
  typedef struct packed {
    logic load;  // capture a new request
    logic step;  // run one selection attempt
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic done;  // current attempt finishes the request
  } status_t;

endpackage

### hdl/lruvs_ctrl.sv
// ----------------------------------------------------------------------------
// LRU victim select controller
// Two-state sequencer: waits for a request, then steps the datapath one
// attempt per cycle until the datapath reports the request finished.
// ----------------------------------------------------------------------------
module lruvs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output lruvs_pkg::cmd_t    cmd_o,
  input  lruvs_pkg::status_t status_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (status_i.done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == ST_RUN);

endmodule

### hdl/lruvs_dp.sv
// ----------------------------------------------------------------------------
// LRU victim select datapath
// Per-way age registers, configuration registers, request capture, the
// oldest/first-invalid search, MRU update, attempt counter and result register.
// ----------------------------------------------------------------------------
module lruvs_dp #(
  parameter int WAYS         = 8,
  parameter int MAX_ATTEMPTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lruvs_pkg::cmd_t                     cmd_i,
  output lruvs_pkg::status_t                  status_o,
  input  logic                                cfg_we_i,
  input  logic [lruvs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lruvs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [lruvs_pkg::OP_W-1:0]          op_i,
  input  logic [lruvs_pkg::WAY_FIELD_W-1:0]   touched_way_i,
  input  logic [lruvs_pkg::MASK_W-1:0]        valid_mask_i,
  input  logic [lruvs_pkg::MASK_W-1:0]        replaceable_mask_i,
  input  logic [lruvs_pkg::MASK_W-1:0]        lower_present_mask_i,
  output logic                                done_o,
  output logic [lruvs_pkg::WAY_FIELD_W-1:0]   chosen_way_o,
  output logic [lruvs_pkg::AGE_FIELD_W-1:0]   prior_age_o,
  output logic                                used_invalid_o,
  output logic [lruvs_pkg::ATT_FIELD_W-1:0]   attempt_index_o
);

  localparam int WiW    = $clog2(WAYS);
  localparam int CntW   = $clog2(MAX_ATTEMPTS + 1);
  localparam int MaskW  = lruvs_pkg::MASK_W;
  localparam int RsvW   = lruvs_pkg::RSV_W;
  localparam int LimW   = lruvs_pkg::LIMIT_W;
  localparam int WayFW  = lruvs_pkg::WAY_FIELD_W;
  localparam int AgeFW  = lruvs_pkg::AGE_FIELD_W;
  localparam int AttFW  = lruvs_pkg::ATT_FIELD_W;
  localparam int OpW    = lruvs_pkg::OP_W;

  // State and configuration
  logic [WiW-1:0]   age_q [WAYS];
  logic [WiW-1:0]   age_d [WAYS];
  logic [LimW-1:0]  limit_q;
  logic [RsvW-1:0]  rsv_q;

  // Captured request
  logic [OpW-1:0]   op_q;
  logic [WayFW-1:0] tw_q;
  logic [MaskW-1:0] valid_q, repl_q, lower_q;
  logic [CntW-1:0]  att_q;

  // Result register
  logic             done_q;
  logic [WayFW-1:0] way_q;
  logic [AgeFW-1:0] age_res_q;
  logic             inv_q;
  logic [AttFW-1:0] att_res_q;

  // Masks widened to the way count; ways past the mask width read as zero
  logic [WAYS-1:0]  valid_w, repl_w, lower_w;

  for (genvar g = 0; g < WAYS; g++) begin : g_mask
    if (g < MaskW) begin : g_in
      assign valid_w[g] = valid_q[g];
      assign repl_w[g]  = repl_q[g];
      assign lower_w[g] = lower_q[g];
    end else begin : g_out
      assign valid_w[g] = 1'b0;
      assign repl_w[g]  = 1'b0;
      assign lower_w[g] = 1'b0;
    end
  end

  // Region bounds and attempt limit
  logic [RsvW-1:0] res_cnt, lo_cnt;
  logic [WiW-1:0]  range_lo;
  logic [CntW-1:0] lim_m1;
  logic            rsv_path, last_att;

  always_comb begin
    res_cnt  = (int'(rsv_q) > WAYS) ? RsvW'(WAYS) : rsv_q;
    lo_cnt   = (int'(res_cnt) < WAYS) ? res_cnt : '0;
    rsv_path = (op_q == lruvs_pkg::OP_RSV_VICTIM) && (res_cnt != '0);
    range_lo = rsv_path ? '0 : WiW'(lo_cnt);
    if (limit_q == '0) begin
      lim_m1 = '0;
    end else if (int'(limit_q) > MAX_ATTEMPTS) begin
      lim_m1 = CntW'(MAX_ATTEMPTS - 1);
    end else begin
      lim_m1 = CntW'(limit_q - 1'b1);
    end
    last_att = (att_q == lim_m1);
  end

  // Search: first invalid way in range, oldest allowed way in range
  logic [WAYS-1:0] in_range, allow, inv_vec, age_seen;
  logic [WiW-1:0]  max_age, old_way, fi_way;
  logic            any_inv;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      in_range[i] = rsv_path ? (i < int'(res_cnt)) : (i >= int'(lo_cnt));
    end
    inv_vec = in_range & ~valid_w;
    // reserved region ignores the replaceable mask
    allow   = rsv_path ? in_range : (in_range & repl_w);
    any_inv = |inv_vec;

    fi_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (inv_vec[i]) fi_way = WiW'(i);
    end

    // ages are a permutation: mark present ages, take the top one
    age_seen = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (allow[i]) age_seen[age_q[i]] = 1'b1;
    end
    max_age = '0;
    for (int a = 0; a < WAYS; a++) begin
      if (age_seen[a]) max_age = WiW'(a);
    end
    old_way = range_lo;
    for (int i = 0; i < WAYS; i++) begin
      if (allow[i] && (age_q[i] == max_age)) old_way = WiW'(i);
    end
  end

  // Step decision
  logic             mru_en, step_done, r_inv;
  logic [WiW-1:0]   mru_way, tw_idx, age_sel;
  logic [WayFW-1:0] r_way;
  logic [AgeFW-1:0] r_age;
  logic [AttFW-1:0] r_att;
  logic             tw_in;

  always_comb begin
    tw_idx    = WiW'(tw_q);
    tw_in     = (int'(tw_q) < WAYS);
    mru_en    = 1'b0;
    mru_way   = '0;
    step_done = 1'b1;
    r_way     = '0;
    r_age     = '0;
    r_inv     = 1'b0;
    r_att     = '0;
    case (op_q)
      lruvs_pkg::OP_HIT: begin
        mru_way = tw_idx;
        mru_en  = tw_in;
        r_way   = tw_q;
        r_age   = tw_in ? AgeFW'(age_q[tw_idx]) : '0;
      end
      lruvs_pkg::OP_VICTIM, lruvs_pkg::OP_RSV_VICTIM: begin
        mru_en = 1'b1;
        if (any_inv) begin
          mru_way = fi_way;
          r_inv   = 1'b1;
        end else begin
          mru_way = old_way;
          // QBS: retry while the candidate sits in the lower level
          step_done = rsv_path || last_att || !lower_w[old_way];
          r_att     = rsv_path ? '0 : AttFW'(att_q);
        end
        r_way = WayFW'(mru_way);
      end
      default: begin
      end
    endcase
    age_sel = age_q[mru_way];
  end

  assign status_o.done = step_done;

  // MRU update
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      age_d[i] = age_q[i];
      if (cmd_i.step && mru_en) begin
        if (WiW'(i) == mru_way) begin
          age_d[i] = '0;
        end else if (age_q[i] < age_sel) begin
          age_d[i] = age_q[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WAYS; i++) begin
        age_q[i] <= WiW'(i);
      end
      limit_q <= LimW'(1);
      rsv_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      age_q  <= age_d;
      done_q <= cmd_i.step && step_done;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lruvs_pkg::REG_ATTEMPT_LIMIT: limit_q <= cfg_wdata_i[LimW-1:0];
          lruvs_pkg::REG_RESERVED_WAYS: rsv_q   <= cfg_wdata_i[RsvW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Request capture, attempt counter, result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      tw_q    <= touched_way_i;
      valid_q <= valid_mask_i;
      repl_q  <= replaceable_mask_i;
      lower_q <= lower_present_mask_i;
      att_q   <= '0;
    end else if (cmd_i.step && !step_done) begin
      att_q <= att_q + 1'b1;
    end
    if (cmd_i.step && step_done) begin
      way_q     <= r_way;
      age_res_q <= r_age;
      inv_q     <= r_inv;
      att_res_q <= r_att;
    end
  end

  assign done_o          = done_q;
  assign chosen_way_o    = way_q;
  assign prior_age_o     = age_res_q;
  assign used_invalid_o  = inv_q;
  assign attempt_index_o = att_res_q;

endmodule

### hdl/lru_victim_select_with_qbs_top.sv
// ----------------------------------------------------------------------------
// LRU victim select with query-based selection
// Attempts: a request runs one attempt per cycle; hits, invalid-way and
//   reserved-region victims finish in their first attempt, and QBS victims
//   retry up to the attempt limit (MAX_ATTEMPTS at most).
// Sequencing: one request at a time, set by the single search/MRU update
//   unit; busy drops in the cycle the result is shown.
// Reset: ages go to way i = age i, attempt limit 1, no reserved ways.
// ----------------------------------------------------------------------------
module lru_victim_select_with_qbs_top #(
  parameter int WAYS         = 8,
  parameter int MAX_ATTEMPTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cfg_we_i,
  input  logic [lruvs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lruvs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [lruvs_pkg::OP_W-1:0]          op_i,
  input  logic [lruvs_pkg::WAY_FIELD_W-1:0]   touched_way_i,
  input  logic [lruvs_pkg::MASK_W-1:0]        valid_mask_i,
  input  logic [lruvs_pkg::MASK_W-1:0]        replaceable_mask_i,
  input  logic [lruvs_pkg::MASK_W-1:0]        lower_present_mask_i,
  output logic                                done_o,
  output logic [lruvs_pkg::WAY_FIELD_W-1:0]   chosen_way_o,
  output logic [lruvs_pkg::AGE_FIELD_W-1:0]   prior_age_o,
  output logic                                used_invalid_o,
  output logic [lruvs_pkg::ATT_FIELD_W-1:0]   attempt_index_o
);

  lruvs_pkg::cmd_t    cmd;
  lruvs_pkg::status_t status;

  lruvs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  lruvs_dp #(
    .WAYS         (WAYS),
    .MAX_ATTEMPTS (MAX_ATTEMPTS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .op_i                 (op_i),
    .touched_way_i        (touched_way_i),
    .valid_mask_i         (valid_mask_i),
    .replaceable_mask_i   (replaceable_mask_i),
    .lower_present_mask_i (lower_present_mask_i),
    .done_o               (done_o),
    .chosen_way_o         (chosen_way_o),
    .prior_age_o          (prior_age_o),
    .used_invalid_o       (used_invalid_o),
    .attempt_index_o      (attempt_index_o)
  );

endmodule

### hdl/lruvs_checker.sv
// ----------------------------------------------------------------------------
// LRU victim select port checker
// Port-level properties of the request/result sequencing, bound to the top.
// ----------------------------------------------------------------------------
module lruvs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              done_o,
  input logic                              used_invalid_o,
  input logic [lruvs_pkg::ATT_FIELD_W-1:0] attempt_index_o
);

  // accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // result is shown only once the block has gone idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // every request that finishes produces a result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("request finished without a result");

  // one result per request: the strobe does not repeat back to back
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // invalid-way victims never go through QBS retries
  a_inv_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && used_invalid_o) |-> (attempt_index_o == '0))
    else $error("invalid-way victim with nonzero attempt index");

endmodule

bind lru_victim_select_with_qbs_top lruvs_checker u_lruvs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .used_invalid_o  (used_invalid_o),
  .attempt_index_o (attempt_index_o)
);
